// File: sv/tahs_pkg.sv
// ============================================================================
// tahs_pkg: shared types and constants for the homing sequencer
// Widths, action and register codes, phase and status codes, lane structs.
// ============================================================================
package tahs_pkg;

    localparam int AXIS_COUNT  = 3;
    localparam int COUNT_WIDTH = 24;
    localparam int POS_W       = 32;
    localparam int INTERVAL_W  = 16;
    localparam int ACTION_W    = 4;
    localparam int CODE_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int PHASE_W     = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TIMER     = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_SEEK_FAST = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_SEEK_SLOW = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_BACKOFF   = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_CLR_RES   = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_CLR_FAULT = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_STOP      = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_LOAD      = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_ENABLE    = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_DISABLE   = 4'd9;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_IVL    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_IVL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_IVL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEEK_LIMIT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_CNT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_STARTUP_IVL = 3'd6;

    // Configuration reset values
    localparam logic [AXIS_COUNT-1:0]  RST_INVERT      = '0;
    localparam logic [INTERVAL_W-1:0]  RST_FAST_IVL    = 16'd200;
    localparam logic [INTERVAL_W-1:0]  RST_SLOW_IVL    = 16'd1000;
    localparam logic [INTERVAL_W-1:0]  RST_BACKOFF_IVL = 16'd500;
    localparam logic [COUNT_WIDTH-1:0] RST_SEEK_LIMIT  = 24'd40000;
    localparam logic [COUNT_WIDTH-1:0] RST_BACKOFF_CNT = 24'd400;
    localparam logic [INTERVAL_W-1:0]  RST_STARTUP_IVL = 16'd100;

    // Sequencer phase
    localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_SEEK    = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_BACKOFF = 2'd2;

    // Home status
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FAILED  = 2'd3;

    localparam logic [CODE_W-1:0] FAULT_CLEAR  = 4'd0;
    localparam logic [CODE_W-1:0] FAULT_TRAVEL = 4'd1;

    // Command broadcast from the sequencer to every axis lane
    typedef struct packed {
        logic seek_event;   // fold endstop triggers into pending
        logic set_pending;  // start: mark axis pending
        logic step;         // issue a step this request
        logic dir_pos;      // 1 positive (seek, pending axes only), 0 negative (all)
        logic load;         // load a new position
    } tahs_lane_cmd_t;

    // Per-request status produced by the sequencer
    typedef struct packed {
        logic                  dir_positive;
        logic                  motors_enabled;
        logic                  timer_running;
        logic [INTERVAL_W-1:0] next_interval;
        logic [STATUS_W-1:0]   home_status;
        logic [CODE_W-1:0]     fault_state;
        logic                  accepted;
    } tahs_status_t;

    // Complete result as buffered at the output
    typedef struct packed {
        logic [AXIS_COUNT-1:0]            step_mask;
        tahs_status_t                     status;
        logic [AXIS_COUNT-1:0][POS_W-1:0] pos;
    } tahs_result_t;

    // An interval of zero counts as one
    function automatic logic [INTERVAL_W-1:0] at_least_one(input logic [INTERVAL_W-1:0] v);
        logic [INTERVAL_W-1:0] r;
        r = (v == '0) ? {{(INTERVAL_W-1){1'b0}}, 1'b1} : v;
        return r;
    endfunction

endpackage

// File: sv/tahs_lane.sv
// ============================================================================
// tahs_lane: one axis lane
// Holds the axis position and its pending flag, detects the endstop trigger
// and applies steps and loads as commanded by the sequencer.
// ============================================================================
module tahs_lane
    import tahs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tahs_lane_cmd_t   cmd,
    input  logic             endstop_raw,
    input  logic             invert,
    input  logic [POS_W-1:0] load_pos,
    output logic             pend_after,
    output logic             stepped,
    output logic [POS_W-1:0] pos_next
);

    logic             pending_reg;
    logic             pending_next;
    logic [POS_W-1:0] pos_reg;

    // Pending after this event's endstop sample
    assign pend_after = pending_reg & ~(endstop_raw ^ invert);

    // Seek steps only axes still pending; backoff steps every axis
    assign stepped = cmd.step & (cmd.dir_pos ? pend_after : 1'b1);

    always_comb
    begin
        pending_next = pending_reg;
        if (cmd.set_pending)
        begin
            pending_next = 1'b1;
        end
        else if (cmd.seek_event)
        begin
            pending_next = pend_after;
        end
    end

    // Position update, wraps at 32 bits
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.load)
        begin
            pos_next = load_pos;
        end
        else if (stepped)
        begin
            pos_next = cmd.dir_pos ? pos_reg + POS_W'(1) : pos_reg - POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

// File: sv/tahs_ctrl.sv
// ============================================================================
// tahs_ctrl: homing sequencer and lane merge
// Holds configuration, phase, event count and status; merges the lanes'
// pending flags to decide done, travel fault or step for each seek timer event.
// ============================================================================
module tahs_ctrl
    import tahs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic [ACTION_W-1:0]    action,
    input  logic [CODE_W-1:0]      stop_code,
    input  logic [AXIS_COUNT-1:0]  pend_after,
    input  logic                   cfg_fire,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [AXIS_COUNT-1:0]  invert_mask,
    output tahs_lane_cmd_t         cmd,
    output tahs_status_t           status
);

    // Configuration registers
    logic [AXIS_COUNT-1:0]  invert_reg;
    logic [INTERVAL_W-1:0]  fast_ivl_reg;
    logic [INTERVAL_W-1:0]  slow_ivl_reg;
    logic [INTERVAL_W-1:0]  backoff_ivl_reg;
    logic [COUNT_WIDTH-1:0] seek_limit_reg;
    logic [COUNT_WIDTH-1:0] backoff_cnt_reg;
    logic [INTERVAL_W-1:0]  startup_ivl_reg;

    // Sequencer state
    logic [PHASE_W-1:0]     phase_reg,    phase_next;
    logic [COUNT_WIDTH-1:0] events_reg,   events_next;
    logic [INTERVAL_W-1:0]  interval_reg, interval_next;
    logic [STATUS_W-1:0]    status_reg,   status_next;
    logic [CODE_W-1:0]      fault_reg,    fault_next;
    logic                   enabled_reg,  enabled_next;

    logic started;
    logic acc;
    logic start_ok;
    logic running;

    assign invert_mask = invert_reg;
    assign start_ok    = (phase_reg == PHASE_IDLE) && (fault_reg == FAULT_CLEAR);

    // Request decode and state update
    always_comb
    begin
        phase_next    = phase_reg;
        events_next   = events_reg;
        interval_next = interval_reg;
        status_next   = status_reg;
        fault_next    = fault_reg;
        enabled_next  = enabled_reg;
        cmd           = '0;
        started       = 1'b0;
        acc           = 1'b0;
        if (in_fire)
        begin
            case (action)
                ACT_TIMER:
                begin
                    if (phase_reg == PHASE_SEEK)
                    begin
                        cmd.seek_event = 1'b1;
                        if (pend_after == '0)
                        begin
                            phase_next  = PHASE_IDLE;
                            status_next = ST_DONE;
                        end
                        else if (events_reg >= seek_limit_reg)
                        begin
                            fault_next   = FAULT_TRAVEL;
                            enabled_next = 1'b0;
                            phase_next   = PHASE_IDLE;
                            status_next  = ST_FAILED;
                        end
                        else
                        begin
                            cmd.step    = 1'b1;
                            cmd.dir_pos = 1'b1;
                            events_next = events_reg + COUNT_WIDTH'(1);
                        end
                    end
                    else if (phase_reg == PHASE_BACKOFF)
                    begin
                        if (events_reg >= backoff_cnt_reg)
                        begin
                            phase_next  = PHASE_IDLE;
                            status_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.step    = 1'b1;
                            events_next = events_reg + COUNT_WIDTH'(1);
                        end
                    end
                end
                ACT_SEEK_FAST, ACT_SEEK_SLOW, ACT_BACKOFF:
                begin
                    if (start_ok)
                    begin
                        started         = 1'b1;
                        acc             = 1'b1;
                        enabled_next    = 1'b1;
                        status_next     = ST_RUNNING;
                        events_next     = '0;
                        cmd.set_pending = 1'b1;
                        if (action == ACT_BACKOFF)
                        begin
                            phase_next    = PHASE_BACKOFF;
                            interval_next = at_least_one(backoff_ivl_reg);
                        end
                        else
                        begin
                            phase_next    = PHASE_SEEK;
                            interval_next = at_least_one((action == ACT_SEEK_FAST) ?
                                                         fast_ivl_reg : slow_ivl_reg);
                        end
                    end
                end
                ACT_CLR_RES:
                begin
                    if (status_reg != ST_RUNNING)
                    begin
                        status_next = ST_NONE;
                        acc         = 1'b1;
                    end
                end
                ACT_CLR_FAULT:
                begin
                    if (phase_reg == PHASE_IDLE)
                    begin
                        fault_next  = FAULT_CLEAR;
                        status_next = ST_NONE;
                        acc         = 1'b1;
                    end
                end
                ACT_STOP:
                begin
                    phase_next   = PHASE_IDLE;
                    status_next  = ST_FAILED;
                    fault_next   = stop_code;
                    enabled_next = 1'b0;
                end
                ACT_LOAD:
                begin
                    cmd.load = 1'b1;
                end
                ACT_ENABLE:
                begin
                    enabled_next = 1'b1;
                end
                ACT_DISABLE:
                begin
                    if (phase_reg == PHASE_IDLE)
                    begin
                        enabled_next = 1'b0;
                        acc          = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Status reflects state after the request
    assign running = (phase_next != PHASE_IDLE);

    always_comb
    begin
        status.dir_positive   = (phase_next == PHASE_SEEK);
        status.motors_enabled = enabled_next;
        status.timer_running  = running;
        status.next_interval  = '0;
        if (running)
        begin
            status.next_interval = started ? at_least_one(startup_ivl_reg) : interval_next;
        end
        status.home_status    = status_next;
        status.fault_state    = fault_next;
        status.accepted       = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_IDLE;
            events_reg   <= '0;
            interval_reg <= '0;
            status_reg   <= ST_NONE;
            fault_reg    <= FAULT_CLEAR;
            enabled_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            events_reg   <= events_next;
            interval_reg <= interval_next;
            status_reg   <= status_next;
            fault_reg    <= fault_next;
            enabled_reg  <= enabled_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg      <= RST_INVERT;
            fast_ivl_reg    <= RST_FAST_IVL;
            slow_ivl_reg    <= RST_SLOW_IVL;
            backoff_ivl_reg <= RST_BACKOFF_IVL;
            seek_limit_reg  <= RST_SEEK_LIMIT;
            backoff_cnt_reg <= RST_BACKOFF_CNT;
            startup_ivl_reg <= RST_STARTUP_IVL;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_INVERT:      invert_reg      <= cfg_data[AXIS_COUNT-1:0];
                CFG_FAST_IVL:    fast_ivl_reg    <= cfg_data[INTERVAL_W-1:0];
                CFG_SLOW_IVL:    slow_ivl_reg    <= cfg_data[INTERVAL_W-1:0];
                CFG_BACKOFF_IVL: backoff_ivl_reg <= cfg_data[INTERVAL_W-1:0];
                CFG_SEEK_LIMIT:  seek_limit_reg  <= cfg_data[COUNT_WIDTH-1:0];
                CFG_BACKOFF_CNT: backoff_cnt_reg <= cfg_data[COUNT_WIDTH-1:0];
                CFG_STARTUP_IVL: startup_ivl_reg <= cfg_data[INTERVAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: sv/three_axis_homing_sequencer_top.sv
// ============================================================================
// three_axis_homing_sequencer_top: three-axis stepper homing sequencer
// Command and timer-event driven seek/backoff control with per-axis lanes
// and a two-entry output buffer.
// ============================================================================
// For each request (a timer event or a command) the axis lanes
// and the sequencer update all state in the cycle the request is accepted, and
// the result enters a two-entry output buffer, so a request can be accepted
// every cycle while the skid entry is empty, and requests keep flowing while
// one result waits to be taken. Results are registered before they appear.
// Configuration writes are accepted every cycle; indexes past the last
// register are ignored.
module three_axis_homing_sequencer_top
    import tahs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // request channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ACTION_W-1:0]     action,
    input  logic [AXIS_COUNT-1:0]   endstop_raw,
    input  logic [CODE_W-1:0]       stop_code,
    input  logic signed [POS_W-1:0] load_pos_a,
    input  logic signed [POS_W-1:0] load_pos_b,
    input  logic signed [POS_W-1:0] load_pos_c,
    // result channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [AXIS_COUNT-1:0]   step_mask,
    output logic                    dir_positive,
    output logic                    motors_enabled,
    output logic                    timer_running,
    output logic [INTERVAL_W-1:0]   next_interval,
    output logic [STATUS_W-1:0]     home_status,
    output logic [CODE_W-1:0]       fault_state,
    output logic                    accepted,
    output logic signed [POS_W-1:0] pos_a,
    output logic signed [POS_W-1:0] pos_b,
    output logic signed [POS_W-1:0] pos_c,
    // configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    logic                             in_fire;
    logic                             out_take;
    tahs_lane_cmd_t                   cmd;
    tahs_status_t                     status;
    logic [AXIS_COUNT-1:0]            invert_mask;
    logic [AXIS_COUNT-1:0]            pend_after;
    logic [AXIS_COUNT-1:0]            stepped;
    logic [AXIS_COUNT-1:0][POS_W-1:0] load_pos;
    logic [AXIS_COUNT-1:0][POS_W-1:0] pos_next;
    tahs_result_t                     result;

    // Output buffer
    tahs_result_t out_reg,       out_next;
    tahs_result_t skid_reg,      skid_next;
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~skid_valid_reg;
    assign in_fire   = in_valid & in_ready;
    assign out_take  = out_valid_reg & out_ready;

    assign load_pos[0] = load_pos_a;
    assign load_pos[1] = load_pos_b;
    assign load_pos[2] = load_pos_c;

    // Sequencer and lane merge
    tahs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .action      (action),
        .stop_code   (stop_code),
        .pend_after  (pend_after),
        .cfg_fire    (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .invert_mask (invert_mask),
        .cmd         (cmd),
        .status      (status)
    );

    // One lane per axis
    for (genvar g = 0; g < AXIS_COUNT; g++)
    begin : g_lane
        tahs_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .endstop_raw (endstop_raw[g]),
            .invert      (invert_mask[g]),
            .load_pos    (load_pos[g]),
            .pend_after  (pend_after[g]),
            .stepped     (stepped[g]),
            .pos_next    (pos_next[g])
        );
    end

    assign result.step_mask = stepped;
    assign result.status    = status;
    assign result.pos       = pos_next;

    // Output register plus skid entry
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Result ports
    assign out_valid      = out_valid_reg;
    assign step_mask      = out_reg.step_mask;
    assign dir_positive   = out_reg.status.dir_positive;
    assign motors_enabled = out_reg.status.motors_enabled;
    assign timer_running  = out_reg.status.timer_running;
    assign next_interval  = out_reg.status.next_interval;
    assign home_status    = out_reg.status.home_status;
    assign fault_state    = out_reg.status.fault_state;
    assign accepted       = out_reg.status.accepted;
    assign pos_a          = out_reg.pos[0];
    assign pos_b          = out_reg.pos[1];
    assign pos_c          = out_reg.pos[2];

endmodule
